// ----- hdl/lfu_pkg.sv -----
package lfu_pkg;

	localparam int CAPACITY   = 16;
	localparam int KEY_BITS   = 32;
	localparam int VALUE_BITS = 32;

	localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int OCC_W   = $clog2(CAPACITY + 1);
	localparam int CFG_W   = 5;
	localparam int CMP_W   = (OCC_W > CFG_W) ? OCC_W : CFG_W;
	localparam int CNT_W   = 32;
	localparam int STAMP_W = 64;
	localparam int IO_W    = 32;

	localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(16);

	typedef enum logic [1:0] {
		CMD_NONE    = 2'd0,
		CMD_TOUCH   = 2'd1,
		CMD_INSTALL = 2'd2
	} cmd_op_t;

	// write command broadcast to every cell; the cell's select bit picks the target
	typedef struct packed {
		cmd_op_t               op;
		logic                  wr_val;
		logic [KEY_BITS-1:0]   key;
		logic [VALUE_BITS-1:0] value;
		logic [STAMP_W-1:0]    stamp;
	} cmd_t;

	// running eviction candidate passed along the chain
	typedef struct packed {
		logic               vld;
		logic [CNT_W-1:0]   cnt;
		logic [STAMP_W-1:0] stamp;
		logic [IDX_W-1:0]   idx;
	} best_t;

endpackage

// ----- hdl/lfu_cell.sv -----
module lfu_cell
	import lfu_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [IDX_W-1:0]      idx,
	input  logic                  vld,
	input  logic [KEY_BITS-1:0]   look_key,
	output logic                  match,
	output logic [VALUE_BITS-1:0] value_out,
	input  logic                  sel,
	input  cmd_t                  cmd,
	input  best_t                 best_in,
	output best_t                 best_out
);

	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] value_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [STAMP_W-1:0]    stamp_q;
	logic                  own_better;
	best_t                 best_d;

	assign match     = vld && (key_q == look_key);
	assign value_out = value_q;

	always_ff @(posedge clk) begin
		if (sel) begin
			case (cmd.op)
				CMD_TOUCH: begin
					if (cnt_q != '1) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					stamp_q <= cmd.stamp;
					if (cmd.wr_val) begin
						value_q <= cmd.value;
					end
				end
				CMD_INSTALL: begin
					key_q   <= cmd.key;
					value_q <= cmd.value;
					cnt_q   <= CNT_W'(1);
					stamp_q <= cmd.stamp;
				end
				default: ;
			endcase
		end
	end

	// take over the candidate only when strictly smaller, so the lowest slot wins ties
	always_comb begin
		own_better = vld && (!best_in.vld || (cnt_q < best_in.cnt) ||
			((cnt_q == best_in.cnt) && (stamp_q < best_in.stamp)));
		if (own_better) begin
			best_d.vld   = 1'b1;
			best_d.cnt   = cnt_q;
			best_d.stamp = stamp_q;
			best_d.idx   = idx;
		end else begin
			best_d = best_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_out <= '0;
		end else begin
			best_out <= best_d;
		end
	end

endmodule

// ----- hdl/lfu_cache.sv -----
// LFU key-value cache with oldest-use tiebreak, built as a row of slot cells.
// Request channel: a request (req_type, key, value) is taken on a clock edge
// with start high and busy low. busy stays high until its result is out.
// Result channel: done pulses for one cycle with hit and read_value; the
// receiver cannot stall, so the result must be taken in that cycle.
// Config: capacity is written on an edge with cap_we high; the user must do
// so only while idle, as the block does not enforce it. Hits, gets, drops and
// puts that fill a free slot pass the look and decide states, then raise done.
// A put of a new key into a full store also waits in the sweep state for the
// eviction candidate to ripple through the whole chain, one cell per cycle.
// busy is low during the done cycle, so the next request can be taken at the
// edge that ends it.
// Reset: occupancy and use clock clear, capacity returns to 16; slot
// contents are left as they are and only occupied slots are ever read.
module lfu_cache
	import lfu_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic             req_type,
	input  logic [IO_W-1:0]  key,
	input  logic [IO_W-1:0]  value,
	input  logic             cap_we,
	input  logic [CFG_W-1:0] cap_wdata,
	output logic             done,
	output logic             hit,
	output logic [IO_W-1:0]  read_value
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_LOOK  = 4'b0010,
		ST_DEC   = 4'b0100,
		ST_SWEEP = 4'b1000
	} state_t;

	state_t                state_q;
	logic [CFG_W-1:0]      cap_q;
	logic [OCC_W-1:0]      occ_q;
	logic [STAMP_W-1:0]    clock_q;
	logic                  put_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] value_q;
	logic [CAPACITY-1:0]   match_q;
	logic [IDX_W-1:0]      sweep_q;

	logic [KEY_BITS+IO_W-1:0]   key_ext;
	logic [VALUE_BITS+IO_W-1:0] value_ext;
	logic [VALUE_BITS+IO_W-1:0] rd_ext;
	logic [CMP_W-1:0]      cap_eff;
	logic [CMP_W-1:0]      occ_ext;
	logic [CAPACITY-1:0]   cell_vld;
	logic [CAPACITY-1:0]   cell_match;
	logic [CAPACITY-1:0]   cell_sel;
	logic [VALUE_BITS-1:0] cell_value [CAPACITY];
	best_t                 chain [CAPACITY+1];
	logic [IDX_W-1:0]      hit_idx;
	cmd_t                  cmd;

	assign key_ext   = {{IO_W{1'b0}}, key};
	assign value_ext = {{IO_W{1'b0}}, value};
	assign busy      = (state_q != ST_IDLE);
	assign occ_ext   = CMP_W'(occ_q);
	assign cap_eff   = (CMP_W'(cap_q) > CMP_W'(CAPACITY)) ? CMP_W'(CAPACITY) : CMP_W'(cap_q);
	assign chain[0]  = '0;

	always_comb begin
		hit_idx = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (match_q[i]) begin
				hit_idx = IDX_W'(i);
			end
		end
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		assign cell_vld[g] = (occ_q > OCC_W'(g));
		lfu_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.idx       (IDX_W'(g)),
			.vld       (cell_vld[g]),
			.look_key  (key_q),
			.match     (cell_match[g]),
			.value_out (cell_value[g]),
			.sel       (cell_sel[g]),
			.cmd       (cmd),
			.best_in   (chain[g]),
			.best_out  (chain[g+1])
		);
	end

	// write command toward the cells
	always_comb begin
		cmd.op     = CMD_NONE;
		cmd.wr_val = put_q;
		cmd.key    = key_q;
		cmd.value  = value_q;
		cmd.stamp  = clock_q;
		cell_sel   = '0;
		if (state_q == ST_DEC) begin
			if (|match_q) begin
				cmd.op = CMD_TOUCH;
				cell_sel[hit_idx] = 1'b1;
			end else if (put_q && (cap_eff != '0) && (occ_ext < cap_eff)) begin
				cmd.op = CMD_INSTALL;
				cell_sel[occ_q[IDX_W-1:0]] = 1'b1;
			end
		end else if ((state_q == ST_SWEEP) && (sweep_q == IDX_W'(CAPACITY - 1))) begin
			cmd.op = CMD_INSTALL;
			cell_sel[chain[CAPACITY].idx] = 1'b1;
		end
	end

	assign rd_ext = {{IO_W{1'b0}}, cell_value[hit_idx]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cap_q   <= CAP_RESET;
			occ_q   <= '0;
			clock_q <= '0;
			sweep_q <= '0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			if (cap_we) begin
				cap_q <= cap_wdata;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					state_q <= ST_DEC;
				end
				ST_DEC: begin
					if (|match_q) begin
						clock_q <= clock_q + STAMP_W'(1);
						done    <= 1'b1;
						state_q <= ST_IDLE;
					end else if (!put_q || (cap_eff == '0)) begin
						done    <= 1'b1;
						state_q <= ST_IDLE;
					end else if (occ_ext < cap_eff) begin
						occ_q   <= occ_q + OCC_W'(1);
						clock_q <= clock_q + STAMP_W'(1);
						done    <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						sweep_q <= '0;
						state_q <= ST_SWEEP;
					end
				end
				ST_SWEEP: begin
					// hold until the candidate has passed every cell
					if (sweep_q == IDX_W'(CAPACITY - 1)) begin
						clock_q <= clock_q + STAMP_W'(1);
						done    <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						sweep_q <= sweep_q + IDX_W'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && start) begin
			put_q   <= req_type;
			key_q   <= key_ext[KEY_BITS-1:0];
			value_q <= value_ext[VALUE_BITS-1:0];
		end
		if (state_q == ST_LOOK) begin
			match_q <= cell_match;
		end
		if (state_q == ST_DEC) begin
			hit        <= |match_q;
			read_value <= ((|match_q) && !put_q) ? rd_ext[IO_W-1:0] : '0;
		end else if (state_q == ST_SWEEP) begin
			hit        <= 1'b0;
			read_value <= '0;
		end
	end

endmodule
